// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame deframer, clocked on clock
// and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ws_dfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame deframer package
// Types and constants shared by the parser front end, the command queue and
// the result back end.
// ----------------------------------------------------------------------------
package ws_dfr_pkg;

   // Parser phases.
   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_MASK = 3'd3,
      PH_PAY  = 3'd4
   } phase_type;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   localparam logic [6:0]  LEN_CODE_EXT16    = 7'd126;
   localparam logic [6:0]  LEN_CODE_EXT64    = 7'd127;
   localparam logic [1:0]  MASK_LAST_BYTE    = 2'd3;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

   // One input beat.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       restart;
   } req_type;

   // One result beat.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic        fin_flag;
      logic [3:0]  frame_opcode;
      logic        masked_flag;
      logic [15:0] payload_length;
      logic        truncated;
      logic        last;
   } rsp_type;

   // Command from the parser to the result stage.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  raw_byte;
      logic [7:0]  mask_byte;
      logic [15:0] index;
      logic        fin;
      logic [3:0]  opcode;
      logic        masked;
      logic [15:0] length;
   } cmd_type;

endpackage

// ----- rtl/core/ws_dfr_front.sv -----
// ----------------------------------------------------------------------------
// Frame deframer parser
// Walks the frame header one byte per beat and issues header, payload and
// error commands toward the result stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ws_dfr_front import ws_dfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req,
   input  logic [15:0] max_payload,
   output logic        cmd_push,
   output cmd_type     cmd
);

   phase_type   phase_ff, phase_in, phase_nx, st;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [15:0] len_ff, len_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  hbc_ff, hbc_in;
   logic [15:0] pidx_ff, pidx_in;

   logic [7:0]  b;
   logic [6:0]  code;
   logic [15:0] ext_len;
   logic [16:0] pay_next;
   logic        pay_done;
   logic        hdr_emit;
   logic [7:0]  key_byte;

   assign b        = req.in_byte;
   assign code     = req.in_byte[6:0];
   assign st       = req.restart ? PH_HDR0 : phase_ff;
   assign ext_len  = {len_ff[7:0], b};
   assign pay_next = {1'b0, pidx_ff} + 17'd1;
   assign pay_done = pay_next >= {1'b0, len_ff};

   always_comb begin
      case (pidx_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Next phase.
   always_comb begin
      phase_nx = phase_ff;
      case (st)
         PH_HDR1: begin
            if (code == LEN_CODE_EXT64) begin
               phase_nx = PH_HDR0;
            end else if (code == LEN_CODE_EXT16) begin
               phase_nx = PH_EXT;
            end else if (b[7]) begin
               phase_nx = PH_MASK;
            end else if (code == 7'd0) begin
               phase_nx = PH_HDR0;
            end else begin
               phase_nx = PH_PAY;
            end
         end
         PH_EXT: begin
            if (hbc_ff == 2'd0) begin
               phase_nx = PH_EXT;
            end else if (masked_ff) begin
               phase_nx = PH_MASK;
            end else if (ext_len == 16'd0) begin
               phase_nx = PH_HDR0;
            end else begin
               phase_nx = PH_PAY;
            end
         end
         PH_MASK: begin
            if (hbc_ff != MASK_LAST_BYTE) begin
               phase_nx = PH_MASK;
            end else if (len_ff == 16'd0) begin
               phase_nx = PH_HDR0;
            end else begin
               phase_nx = PH_PAY;
            end
         end
         PH_PAY: begin
            phase_nx = pay_done ? PH_HDR0 : PH_PAY;
         end
         default: begin
            phase_nx = PH_HDR1;
         end
      endcase
   end

   assign phase_in = accept ? phase_nx : phase_ff;

   // Frame fields and command.
   always_comb begin
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      masked_in = masked_ff;
      len_in    = len_ff;
      key_in    = key_ff;
      hbc_in    = hbc_ff;
      pidx_in   = pidx_ff;
      hdr_emit  = 1'b0;
      cmd_push  = 1'b0;
      cmd       = '0;
      cmd.kind  = KIND_HEADER;
      if (accept) begin
         case (st)
            PH_HDR1: begin
               masked_in = b[7];
               key_in    = '0;
               hbc_in    = 2'd0;
               if (code == LEN_CODE_EXT64) begin
                  len_in   = '0;
                  cmd_push = 1'b1;
                  cmd.kind = KIND_ERROR;
               end else if (code == LEN_CODE_EXT16) begin
                  len_in = '0;
               end else begin
                  len_in   = {9'd0, code};
                  hdr_emit = !b[7];
               end
            end
            PH_EXT: begin
               len_in = ext_len;
               if (hbc_ff == 2'd0) begin
                  hbc_in = 2'd1;
               end else begin
                  hbc_in   = 2'd0;
                  hdr_emit = !masked_ff;
               end
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], b};
               if (hbc_ff != MASK_LAST_BYTE) begin
                  hbc_in = hbc_ff + 2'd1;
               end else begin
                  hbc_in   = 2'd0;
                  hdr_emit = 1'b1;
               end
            end
            PH_PAY: begin
               if (pidx_ff < max_payload) begin
                  cmd_push      = 1'b1;
                  cmd.kind      = KIND_PAYLOAD;
                  cmd.raw_byte  = b;
                  cmd.mask_byte = masked_ff ? key_byte : 8'd0;
               end
               pidx_in = pay_done ? 16'd0 : pay_next[15:0];
            end
            default: begin
               fin_in    = b[7];
               opcode_in = b[3:0];
               masked_in = 1'b0;
               len_in    = '0;
               key_in    = '0;
               hbc_in    = 2'd0;
               pidx_in   = '0;
            end
         endcase
         if (hdr_emit) begin
            cmd_push = 1'b1;
            cmd.kind = KIND_HEADER;
            pidx_in  = '0;
         end
      end
      cmd.index  = pidx_ff;
      cmd.fin    = fin_in;
      cmd.opcode = opcode_in;
      cmd.masked = masked_in;
      cmd.length = len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         hbc_ff   <= 2'd0;
         pidx_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         hbc_ff   <= hbc_in;
         pidx_ff  <= pidx_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff    <= fin_in;
      opcode_ff <= opcode_in;
      masked_ff <= masked_in;
      len_ff    <= len_in;
      key_ff    <= key_in;
   end

   `ASSERT_IMPLIES(a_fr_pay_len, phase_ff == PH_PAY, len_ff != 16'd0, "payload phase with zero length")
   `ASSERT_IMPLIES(a_fr_ext_cnt, phase_ff == PH_EXT, hbc_ff <= 2'd1, "extended length count overrun")

endmodule

// ----- rtl/core/ws_dfr_queue.sv -----
// ----------------------------------------------------------------------------
// Frame deframer command queue
// Small first-in first-out buffer that decouples the parser from the result
// stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ws_dfr_queue import ws_dfr_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_ALWAYS(a_q_count_bound, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")
   `ASSERT_IMPLIES(a_q_no_overflow, full, !push, "write into a full queue")

endmodule

// ----- rtl/core/ws_dfr_back.sv -----
// ----------------------------------------------------------------------------
// Frame deframer result stage
// Turns queued commands into result beats: unmasks payload, works out the
// truncation and last marks, and holds the beat in an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ws_dfr_back import ws_dfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] max_payload,
   input  logic        q_empty,
   input  cmd_type     q_data,
   output logic        q_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data
);

   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic [15:0] kept;
   logic [16:0] idx_next;

   assign kept     = (q_data.length < max_payload) ? q_data.length : max_payload;
   assign idx_next = {1'b0, q_data.index} + 17'd1;

   assign q_pop        = !q_empty && (!out_valid_ff || rsp_pop);
   assign out_valid_in = q_pop || (out_valid_ff && !rsp_pop);

   always_comb begin
      out_in                = out_ff;
      if (q_pop) begin
         out_in.kind           = q_data.kind;
         out_in.data_byte      = 8'd0;
         out_in.fin_flag       = q_data.fin;
         out_in.frame_opcode   = q_data.opcode;
         out_in.masked_flag    = q_data.masked;
         out_in.payload_length = q_data.length;
         out_in.truncated      = q_data.length > max_payload;
         case (q_data.kind)
            KIND_HEADER: begin
               out_in.last = kept == 16'd0;
            end
            KIND_PAYLOAD: begin
               out_in.data_byte = q_data.raw_byte ^ q_data.mask_byte;
               out_in.last      = idx_next == {1'b0, kept};
            end
            default: begin
               out_in.payload_length = 16'd0;
               out_in.truncated      = 1'b0;
               out_in.last           = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   `ASSERT_IMPLIES(a_bk_err_last, out_valid_ff && out_ff.kind == KIND_ERROR, out_ff.last, "error beat without last")

endmodule

// ----- rtl/core/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses frames from a byte stream and emits header, payload and error beats.
// ----------------------------------------------------------------------------
// The deframer takes one stream byte per clock and keeps that rate for as
// long as the result side drains. Each byte goes through the parser in the
// cycle it is taken; a byte that produces a result writes one command into a
// small queue of QUEUE_DEPTH entries, and the result stage moves the oldest
// command, when its output register is free or popped, into that register as
// a beat, so a result passes a queue entry and the output register before it
// can be popped. Header bytes, extended length bytes and mask key bytes give
// no payload beat. The header beat follows the last header byte and carries
// the frame's FIN bit, opcode, mask bit, length and the truncation flag; each
// payload byte below max_payload then gives a payload beat with the byte
// unmasked, and the final beat of a frame has last set. A 64-bit length code
// gives a single error beat and the parser returns to looking for a new frame.
// Setting restart on a byte makes it the first header byte of a new frame.
// req_full rises only when the queue is full, which happens when the result
// side holds off pop while commands arrive. max_payload is to be written by
// the user through csr_write_en and csr_write_data only while the block is
// idle, which the block leaves unchecked; it resets to 1024.
// ----------------------------------------------------------------------------

module websocket_frame_deframer import ws_dfr_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_push,
   input  req_type     req_data,
   output logic        req_full,
   // Result stream.
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   // Configuration.
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data
);

   logic [15:0] max_payload_ff, max_payload_in;
   logic        accept;
   logic        cmd_push;
   cmd_type     cmd;
   logic        q_empty;
   logic        q_pop;
   cmd_type     q_data;

   // The receive buffer limit is the only register.
   assign max_payload_in = csr_write_en ? csr_write_data : max_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         max_payload_ff <= max_payload_in;
      end
   end

   // A byte is taken whenever the queue has room, even if it gives no beat.
   assign accept = req_push && !req_full;

   ws_dfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .max_payload (max_payload_ff),
      .cmd_push    (cmd_push),
      .cmd         (cmd)
   );

   ws_dfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   ws_dfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .max_payload (max_payload_ff),
      .q_empty     (q_empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule
